[design/rmsef_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmsef_pkg
// Widths, constants, register indexes and controller states shared by the
// RMS energy follower and its bit-serial arithmetic units.
// ----------------------------------------------------------------------------
package rmsef_pkg;

  // Stream fields
  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 16;
  localparam int COEF_W   = 16;
  localparam int NRG_W    = 16;

  // Block accumulator
  localparam int CNT_W     = 13;
  localparam int SUM_W     = 43;
  localparam int MAX_BLOCK = 4096;
  localparam int MEAN_W    = 31;

  // Levels in Q0.24 with one guard bit for the value one
  localparam int LVL_W = 25;

  // Energy history
  localparam int HIST_DEPTH = 64;
  localparam int PTR_W      = $clog2(HIST_DEPTH);
  localparam int RSUM_W     = 22;

  // Serial multiplier
  localparam int MUL_A_W   = 25;
  localparam int MUL_B_W   = 24;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int MUL_ITERS = MUL_B_W;

  // Serial divider
  localparam int DIV_REM_W  = 25;
  localparam int DIV_NUM_W  = 43;
  localparam int DIV_ITER_W = 6;
  localparam int NRG_QB     = 17;

  // Serial square root
  localparam int RAD_W      = 50;
  localparam int ROOT_W     = 25;
  localparam int SREM_W     = 27;
  localparam int SQRT_ITERS = RAD_W / 2;

  localparam logic [CNT_W-1:0]      COUNT_MAX     = CNT_W'(MAX_BLOCK);
  localparam logic [SUM_W-1:0]      SUM_SAT       = '1;
  localparam logic [MEAN_W-1:0]     MEAN_MAX      = 31'h4000_0000;
  localparam logic [MUL_B_W-1:0]    DECAY_Q24     = 24'd16775539;
  localparam logic [LVL_W-1:0]      PEAK_FLOOR    = 25'd16777;
  localparam logic [LVL_W-1:0]      LEVEL_ONE     = 25'h100_0000;
  localparam logic [COEF_W-1:0]     ATTACK_RESET  = 16'd272;
  localparam logic [COEF_W-1:0]     RELEASE_RESET = 16'd14;
  localparam logic [NRG_W-1:0]      ACTIVE_THR    = 16'd655;
  localparam logic [PROD_W-1:0]     ROUND_HALF    = PROD_W'(32768);
  localparam logic [DIV_ITER_W-1:0] MEAN_ITERS    = DIV_ITER_W'(DIV_NUM_W);
  localparam logic [DIV_ITER_W-1:0] NRG_ITERS     = DIV_ITER_W'(NRG_QB);

  typedef enum logic [0:0] {
    CFG_ATTACK  = 1'b0,
    CFG_RELEASE = 1'b1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_WAIT,
    ST_ACC,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_ENV_GO,
    ST_ENV_WAIT,
    ST_ENV_UPD,
    ST_PEAK,
    ST_PK_GO,
    ST_PK_WAIT,
    ST_PK_UPD,
    ST_NRG_GO,
    ST_NRG_WAIT,
    ST_RING
  } state_e;

endpackage

[design/rmsef_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmsef_mul
// Shift-add multiplier: one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module rmsef_mul import rmsef_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output logic               busy_o,
  output logic [PROD_W-1:0]  prod_o
);

  localparam int CW = $clog2(MUL_ITERS + 1);

  logic              busy_q, busy_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [MUL_A_W-1:0] a_q;
  logic [PROD_W-1:0] p_q, p_d;
  logic [MUL_A_W:0]  hi_sum;

  // add the multiplicand into the upper half when the current bit is set
  assign hi_sum = {1'b0, p_q[PROD_W-1:MUL_B_W]} + (p_q[0] ? {1'b0, a_q} : '0);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    p_d    = p_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(MUL_ITERS);
      p_d    = {{MUL_A_W{1'b0}}, b_i};
    end else if (busy_q) begin
      p_d   = {hi_sum, p_q[MUL_B_W-1:1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    if (start_i) begin
      a_q <= a_i;
    end
  end

  assign busy_o = busy_q;
  assign prod_o = p_q;

endmodule

[design/rmsef_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmsef_div
// Restoring divider: one quotient bit per cycle, numerator bits MSB first.
// The caller seeds a partial remainder that is already below the divisor.
// ----------------------------------------------------------------------------
module rmsef_div import rmsef_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIV_REM_W-1:0]  rem_i,
  input  logic [DIV_NUM_W-1:0]  num_i,
  input  logic [DIV_REM_W-1:0]  den_i,
  input  logic [DIV_ITER_W-1:0] iters_i,
  output logic                  busy_o,
  output logic [DIV_NUM_W-1:0]  quo_o
);

  logic                  busy_q, busy_d;
  logic [DIV_ITER_W-1:0] cnt_q, cnt_d;
  logic [DIV_REM_W-1:0]  rem_q, rem_d;
  logic [DIV_NUM_W-1:0]  num_q, num_d;
  logic [DIV_NUM_W-1:0]  quo_q, quo_d;
  logic [DIV_REM_W-1:0]  den_q;
  logic [DIV_REM_W:0]    trial;
  logic [DIV_REM_W:0]    diff;
  logic                  ge;

  assign trial = {rem_q, num_q[DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = iters_i;
      rem_d  = rem_i;
      num_d  = num_i;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[DIV_REM_W-1:0] : trial[DIV_REM_W-1:0];
      num_d = {num_q[DIV_NUM_W-2:0], 1'b0};
      quo_d = {quo_q[DIV_NUM_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_ITER_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

[design/rmsef_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmsef_sqrt
// Digit-by-digit integer square root: one root bit per cycle, taking two
// radicand bits each step.
// ----------------------------------------------------------------------------
module rmsef_sqrt import rmsef_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic              busy_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int CW = $clog2(SQRT_ITERS + 1);

  logic              busy_q, busy_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [SREM_W-1:0] rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [SREM_W+1:0] cur;
  logic [SREM_W+1:0] trial;
  logic [SREM_W+1:0] diff;
  logic              ge;

  // trial subtrahend is 4*root + 1
  assign cur   = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign diff  = cur - trial;
  assign ge    = (cur >= trial);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(SQRT_ITERS);
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? diff[SREM_W-1:0] : cur[SREM_W-1:0];
      root_d = {root_q[ROOT_W-2:0], ge};
      rad_d  = {rad_q[RAD_W-3:0], 2'b00};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

[design/block_rms_energy_follower.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_rms_energy_follower
// Block RMS of the mono fold, attack/release envelope, decaying peak
// normalization and a 64-entry running mean of the normalized energy.
// ----------------------------------------------------------------------------
// Sample not marked last: ready again once the serial squaring of the sample
//   completes and its square is accumulated.
// Sample marked last: result valid after the 43-step mean divide, 25-step root,
//   24-step multiplies and the 17-step normalizing divide; the peak-decay
//   multiply runs only when the peak decays.
// Reset: coefficients to defaults, accumulators and envelope cleared, peak at
//   its floor, history entries read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module block_rms_energy_follower import rmsef_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [COEF_W-1:0] cfg_data_i,
  // sample stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,   // [15:0] left_sample, [31:16] right_sample
  input  logic              s_axis_tlast,   // last_in_block
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,   // [15:0] energy, [31:16] smoothed_energy
  output logic              m_axis_tuser    // input_active
);

  state_e state_q, state_d;

  logic [COEF_W-1:0] attack_q, release_q;
  logic              last_q, last_d;
  logic              rise_q, rise_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [LVL_W-1:0]  env_q, env_d;
  logic [LVL_W-1:0]  peak_q, peak_d;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic [RSUM_W-1:0] rsum_q, rsum_d;
  logic [HIST_DEPTH-1:0] vld_q, vld_d;

  logic [NRG_W-1:0]  ring_mem [HIST_DEPTH];
  logic [NRG_W-1:0]  old_q;
  logic              oldv_q;

  logic              m_tvalid_q;
  logic [31:0]       m_tdata_q;
  logic              m_tuser_q;

  // unit handshakes and operands
  logic                  mul_start, div_start, sqrt_start;
  logic                  mul_busy, div_busy, sqrt_busy;
  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [PROD_W-1:0]     prod;
  logic [DIV_REM_W-1:0]  div_rem, div_den;
  logic [DIV_NUM_W-1:0]  div_num, quo;
  logic [DIV_ITER_W-1:0] div_iters;
  logic [RAD_W-1:0]      rad;
  logic [ROOT_W-1:0]     root;

  logic              in_take;
  logic              ring_take;
  logic [SAMPLE_W:0] mono_sum;
  logic [SAMPLE_W+1:0] mono_abs;
  logic [MAG_W-1:0]  mag;
  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  sum_sat;
  logic [MEAN_W-1:0] mean;
  logic              rise;
  logic [LVL_W-1:0]  ediff;
  logic [COEF_W-1:0] coef;
  logic [PROD_W-1:0] rnd;
  logic [LVL_W-1:0]  step;
  logic [LVL_W-1:0]  decayed;
  logic [LVL_W+NRG_W-1:0] nrg_num;
  logic [NRG_W-1:0]  nrg;
  logic [NRG_W-1:0]  old_nrg;
  logic [RSUM_W-1:0] rsum_new;
  logic [NRG_W-1:0]  smoothed;

  // --------------------------------------------------------------------------
  // Arithmetic units
  // --------------------------------------------------------------------------
  rmsef_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .prod_o  (prod)
  );

  rmsef_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (div_rem),
    .num_i   (div_num),
    .den_i   (div_den),
    .iters_i (div_iters),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  rmsef_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (rad),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  // --------------------------------------------------------------------------
  // Datapath terms
  // --------------------------------------------------------------------------
  assign in_take = s_axis_tvalid && s_axis_tready;

  // floor((l + r) / 2) magnitude: negative sums round away from zero
  assign mono_sum = {s_axis_tdata[15], s_axis_tdata[15:0]}
                  + {s_axis_tdata[31], s_axis_tdata[31:16]};
  assign mono_abs = mono_sum[SAMPLE_W] ? ({1'b0, ~mono_sum} + (SAMPLE_W+2)'(2))
                                       : {1'b0, mono_sum};
  assign mag      = mono_abs[MAG_W:1];

  assign sum_ext = {1'b0, sum_q} + (SUM_W+1)'(prod[2*MAG_W-1:0]);
  assign sum_sat = sum_ext[SUM_W] ? SUM_SAT : sum_ext[SUM_W-1:0];

  assign mean = (quo > DIV_NUM_W'(MEAN_MAX)) ? MEAN_MAX : quo[MEAN_W-1:0];
  assign rad  = RAD_W'({mean, 18'b0});

  assign rise  = (LVL_W'(root) > env_q);
  assign ediff = rise ? (LVL_W'(root) - env_q) : (env_q - LVL_W'(root));
  assign coef  = rise ? attack_q : release_q;

  assign rnd     = prod + ROUND_HALF;
  assign step    = rnd[16 +: LVL_W];
  assign decayed = prod[MUL_B_W +: LVL_W];

  // envelope * 65535
  assign nrg_num = {env_q, {NRG_W{1'b0}}} - (LVL_W+NRG_W)'(env_q);

  assign nrg      = (|quo[DIV_NUM_W-1:NRG_W]) ? '1 : quo[NRG_W-1:0];
  assign old_nrg  = oldv_q ? old_q : '0;
  assign rsum_new = rsum_q - RSUM_W'(old_nrg) + RSUM_W'(nrg);
  assign smoothed = rsum_new[PTR_W +: NRG_W];

  assign ring_take = (state_q == ST_RING) && (!m_tvalid_q || m_axis_tready);

  // --------------------------------------------------------------------------
  // Controller
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_take) state_d = ST_SQ_WAIT;
      ST_SQ_WAIT:   if (!mul_busy) state_d = ST_ACC;
      ST_ACC:       state_d = last_q ? ST_DIV_GO : ST_IDLE;
      ST_DIV_GO:    state_d = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (!div_busy) state_d = ST_SQRT_GO;
      ST_SQRT_GO:   state_d = ST_SQRT_WAIT;
      ST_SQRT_WAIT: if (!sqrt_busy) state_d = ST_ENV_GO;
      ST_ENV_GO:    state_d = ST_ENV_WAIT;
      ST_ENV_WAIT:  if (!mul_busy) state_d = ST_ENV_UPD;
      ST_ENV_UPD:   state_d = ST_PEAK;
      ST_PEAK:      state_d = (env_q > peak_q) ? ST_NRG_GO : ST_PK_GO;
      ST_PK_GO:     state_d = ST_PK_WAIT;
      ST_PK_WAIT:   if (!mul_busy) state_d = ST_PK_UPD;
      ST_PK_UPD:    state_d = ST_NRG_GO;
      ST_NRG_GO:    state_d = ST_NRG_WAIT;
      ST_NRG_WAIT:  if (!div_busy) state_d = ST_RING;
      ST_RING:      if (ring_take) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    mul_start     = 1'b0;
    div_start     = 1'b0;
    sqrt_start    = 1'b0;
    mul_a         = MUL_A_W'(mag);
    mul_b         = MUL_B_W'(mag);
    div_rem       = '0;
    div_num       = sum_q;
    div_den       = DIV_REM_W'(count_q);
    div_iters     = MEAN_ITERS;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        mul_start     = in_take;
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
      end
      ST_SQRT_GO: begin
        sqrt_start = 1'b1;
      end
      ST_ENV_GO: begin
        mul_start = 1'b1;
        mul_a     = ediff;
        mul_b     = MUL_B_W'(coef);
      end
      ST_PK_GO: begin
        mul_start = 1'b1;
        mul_a     = peak_q;
        mul_b     = DECAY_Q24;
      end
      ST_NRG_GO: begin
        // quotient stays below 2^17, so the upper bits seed the remainder
        div_start = 1'b1;
        div_rem   = DIV_REM_W'(nrg_num >> NRG_QB);
        div_num   = {nrg_num[NRG_QB-1:0], {(DIV_NUM_W-NRG_QB){1'b0}}};
        div_den   = peak_q;
        div_iters = NRG_ITERS;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // State updates
  // --------------------------------------------------------------------------
  always_comb begin
    last_d  = last_q;
    rise_d  = rise_q;
    count_d = count_q;
    sum_d   = sum_q;
    env_d   = env_q;
    peak_d  = peak_q;
    ptr_d   = ptr_q;
    rsum_d  = rsum_q;
    vld_d   = vld_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_take) last_d = s_axis_tlast;
      end
      ST_ACC: begin
        sum_d = sum_sat;
        if (count_q < COUNT_MAX) count_d = count_q + 1'b1;
      end
      ST_DIV_GO: begin
        // divider has latched the block totals at this edge
        sum_d   = '0;
        count_d = '0;
      end
      ST_ENV_GO: begin
        rise_d = rise;
      end
      ST_ENV_UPD: begin
        env_d = rise_q ? (env_q + step) : (env_q - step);
      end
      ST_PEAK: begin
        if (env_q > peak_q) peak_d = env_q;
      end
      ST_PK_UPD: begin
        peak_d = (decayed < PEAK_FLOOR) ? PEAK_FLOOR : decayed;
      end
      ST_RING: begin
        if (ring_take) begin
          ptr_d        = (ptr_q == PTR_W'(HIST_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
          rsum_d       = rsum_new;
          vld_d[ptr_q] = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      attack_q   <= ATTACK_RESET;
      release_q  <= RELEASE_RESET;
      last_q     <= 1'b0;
      rise_q     <= 1'b0;
      count_q    <= '0;
      sum_q      <= '0;
      env_q      <= '0;
      peak_q     <= PEAK_FLOOR;
      ptr_q      <= '0;
      rsum_q     <= '0;
      vld_q      <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      last_q     <= last_d;
      rise_q     <= rise_d;
      count_q    <= count_d;
      sum_q      <= sum_d;
      env_q      <= env_d;
      peak_q     <= peak_d;
      ptr_q      <= ptr_d;
      rsum_q     <= rsum_d;
      vld_q      <= vld_d;
      m_tvalid_q <= ring_take || (m_tvalid_q && !m_axis_tready);
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_ATTACK:  attack_q  <= cfg_data_i;
          CFG_RELEASE: release_q <= cfg_data_i;
        endcase
      end
    end
  end

  // history memory with registered read at the write pointer
  always_ff @(posedge clk_i) begin
    if (ring_take) begin
      ring_mem[ptr_q] <= nrg;
    end
    old_q  <= ring_mem[ptr_q];
    oldv_q <= vld_q[ptr_q];
  end

  // hold the result until the downstream transfer
  always_ff @(posedge clk_i) begin
    if (ring_take) begin
      m_tdata_q <= {smoothed, nrg};
      m_tuser_q <= (smoothed > ACTIVE_THR);
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_ready_units_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !(mul_busy || div_busy || sqrt_busy))
    else $error("sample accepted while an arithmetic unit is busy");

  a_peak_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= PEAK_FLOOR)
    else $error("peak level below its floor");

  a_env_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    env_q <= LEVEL_ONE)
    else $error("envelope above one");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_q && !m_axis_tready) |=> !$past(ring_take))
    else $error("result overwritten before transfer");

endmodule
